@@ sv/hsamp_pkg.sv @@
// shared constants, register indexes and state types of the height grid sampler
package hsamp_pkg;

    // default grid points per side held in the grid memory
    localparam int MAX_GRID_SIZE_DEF = 256;

    // fraction bits of the Q16.16 format
    localparam int FRAC_W = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING = 2'd3;

    // configuration reset values
    localparam logic [8:0]  GRID_SIZE_RST   = 9'd256;
    localparam logic [31:0] ORIGIN_RST      = 32'h0000_0000;
    localparam logic [31:0] INV_SPACING_RST = 32'h0001_0000;

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // front end sequencer
    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } front_state_t;

    // back end sequencer
    typedef enum logic [3:0] {
        B_IDLE,
        B_R0,
        B_R1,
        B_R2,
        B_R3,
        B_TOP,
        B_MB,
        B_BOT,
        B_MZ,
        B_OUT
    } back_state_t;

endpackage

@@ sv/hsamp_ram.sv @@
// generic single-port ram with registered read
module hsamp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write or registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/hsamp_cmd_fifo.sv @@
// small command queue between the front and back ends
module hsamp_cmd_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ sv/hsamp_front.sv @@
// front end: accepts items, drops off-grid writes, maps queries to grid cells
module hsamp_front #(
    parameter int MAX_GRID_SIZE = hsamp_pkg::MAX_GRID_SIZE_DEF,
    localparam int IDX_W = $clog2(MAX_GRID_SIZE),
    localparam int CMD_W = 1 + 2 * IDX_W + 2 * hsamp_pkg::FRAC_W + 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic             kind,
    input  logic [7:0]       column,
    input  logic [7:0]       row,
    input  logic [31:0]      height_value,
    input  logic [31:0]      query_x,
    input  logic [31:0]      query_z,
    input  logic [31:0]      origin_x,
    input  logic [31:0]      origin_z,
    input  logic [31:0]      inv_spacing,
    input  logic [IDX_W-1:0] n_m1,
    output logic             cmd_push,
    input  logic             cmd_full,
    output logic [CMD_W-1:0] cmd_data
);

    localparam int FW  = hsamp_pkg::FRAC_W;
    localparam int G_W = 64 - FW;

    hsamp_pkg::front_state_t state_reg, state_next;

    logic             is_query_reg;
    logic [IDX_W-1:0] col_reg;
    logic [IDX_W-1:0] row_reg;
    logic [31:0]      height_reg;
    logic [31:0]      mag_x_reg;
    logic [31:0]      mag_z_reg;
    logic [63:0]      prod_x_reg;
    logic [63:0]      prod_z_reg;

    logic             accept;
    logic             in_range;
    logic [32:0]      dx;
    logic [32:0]      dz;
    logic [31:0]      mag_x;
    logic [31:0]      mag_z;
    logic [G_W-1:0]   gx;
    logic [G_W-1:0]   gz;
    logic [G_W-1:0]   limit;
    logic [IDX_W-1:0] ix;
    logic [IDX_W-1:0] iz;
    logic [FW-1:0]    tx;
    logic [FW-1:0]    tz;

    assign full   = (state_reg != hsamp_pkg::F_IDLE);
    assign accept = push && (state_reg == hsamp_pkg::F_IDLE);

    // a write is kept only inside the grid size in use
    assign in_range = (int'(column) <= int'(n_m1)) && (int'(row) <= int'(n_m1));

    // offset from the grid corner, negative offsets sit on the edge
    assign dx    = {query_x[31], query_x} - {origin_x[31], origin_x};
    assign dz    = {query_z[31], query_z} - {origin_z[31], origin_z};
    assign mag_x = dx[32] ? '0 : dx[31:0];
    assign mag_z = dz[32] ? '0 : dz[31:0];

    // grid coordinate clamped to the far edge
    assign gx    = prod_x_reg[63:FW];
    assign gz    = prod_z_reg[63:FW];
    assign limit = G_W'({n_m1, {FW{1'b0}}});

    always_comb
    begin
        if (gx > limit)
        begin
            ix = n_m1;
            tx = '0;
        end
        else
        begin
            ix = gx[FW +: IDX_W];
            tx = gx[FW-1:0];
        end
        if (gz > limit)
        begin
            iz = n_m1;
            tz = '0;
        end
        else
        begin
            iz = gz[FW +: IDX_W];
            tz = gz[FW-1:0];
        end
    end

    // command word towards the back end
    always_comb
    begin
        if (is_query_reg)
        begin
            cmd_data = {hsamp_pkg::KIND_QUERY, ix, iz, tx, tz, 32'h0};
        end
        else
        begin
            cmd_data = {hsamp_pkg::KIND_WRITE, col_reg, row_reg, {(2 * FW){1'b0}}, height_reg};
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd_push   = 1'b0;
        case (state_reg)
            hsamp_pkg::F_IDLE:
            begin
                if (push && ((kind == hsamp_pkg::KIND_QUERY) || in_range))
                begin
                    state_next = hsamp_pkg::F_MUL;
                end
            end
            hsamp_pkg::F_MUL:
            begin
                state_next = hsamp_pkg::F_PUSH;
            end
            hsamp_pkg::F_PUSH:
            begin
                if (!cmd_full)
                begin
                    cmd_push   = 1'b1;
                    state_next = hsamp_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = hsamp_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hsamp_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // item capture and scaling products
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_query_reg <= (kind == hsamp_pkg::KIND_QUERY);
            col_reg      <= IDX_W'(column);
            row_reg      <= IDX_W'(row);
            height_reg   <= height_value;
            mag_x_reg    <= mag_x;
            mag_z_reg    <= mag_z;
        end
        if (state_reg == hsamp_pkg::F_MUL)
        begin
            prod_x_reg <= mag_x_reg * inv_spacing;
            prod_z_reg <= mag_z_reg * inv_spacing;
        end
    end

endmodule

@@ sv/hsamp_back.sv @@
// back end: grid writes, four neighbour reads, bilinear blend and result buffer
module hsamp_back #(
    parameter int MAX_GRID_SIZE = hsamp_pkg::MAX_GRID_SIZE_DEF,
    localparam int IDX_W  = $clog2(MAX_GRID_SIZE),
    localparam int CMD_W  = 1 + 2 * IDX_W + 2 * hsamp_pkg::FRAC_W + 32,
    localparam int ADDR_W = $clog2(MAX_GRID_SIZE * MAX_GRID_SIZE)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IDX_W-1:0]  n_m1,
    input  logic [CMD_W-1:0]  cmd_data,
    input  logic              cmd_empty,
    output logic              cmd_pop,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_addr,
    output logic [31:0]       ram_wdata,
    input  logic [31:0]       ram_rdata,
    output logic              empty,
    input  logic              pop,
    output logic [31:0]       sampled_height
);

    localparam int FW = hsamp_pkg::FRAC_W;
    localparam int P_W = 33 + FW + 1;
    localparam logic [ADDR_W-1:0] STRIDE = ADDR_W'(MAX_GRID_SIZE);

    hsamp_pkg::back_state_t state_reg, state_next;

    logic [IDX_W-1:0]   ix_reg;
    logic [IDX_W-1:0]   iz_reg;
    logic [FW-1:0]      tx_reg;
    logic [FW-1:0]      tz_reg;
    logic [31:0]        h00_reg;
    logic [31:0]        h10_reg;
    logic [31:0]        h01_reg;
    logic [31:0]        h11_reg;
    logic [31:0]        top_reg;
    logic [31:0]        bot_reg;
    logic signed [P_W-1:0] prod_reg;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_data_reg;

    logic               head_query;
    logic [IDX_W-1:0]   head_col;
    logic [IDX_W-1:0]   head_row;
    logic [FW-1:0]      head_tx;
    logic [FW-1:0]      head_tz;
    logic [31:0]        head_data;
    logic [IDX_W-1:0]   ix1;
    logic [IDX_W-1:0]   iz1;
    logic signed [32:0] mul_a;
    logic signed [FW:0] mul_b;
    logic signed [P_W-1:0] prod_next;
    logic signed [P_W-1:0] prod_shr;
    logic [31:0]        blend_base;
    logic [32:0]        blend_sum;
    logic               out_load;

    function automatic logic [ADDR_W-1:0] grid_addr(
        input logic [IDX_W-1:0] c,
        input logic [IDX_W-1:0] r
    );
        grid_addr = ADDR_W'(r) * STRIDE + ADDR_W'(c);
    endfunction

    // command word fields
    assign head_query = cmd_data[CMD_W-1];
    assign head_col   = cmd_data[64 + IDX_W +: IDX_W];
    assign head_row   = cmd_data[64 +: IDX_W];
    assign head_tx    = cmd_data[48 +: FW];
    assign head_tz    = cmd_data[32 +: FW];
    assign head_data  = cmd_data[31:0];

    // far neighbours clamped to the grid edge
    assign ix1 = (ix_reg == n_m1) ? ix_reg : ix_reg + 1'b1;
    assign iz1 = (iz_reg == n_m1) ? iz_reg : iz_reg + 1'b1;

    // shared blend multiplier, operands by step
    always_comb
    begin
        mul_b = $signed({1'b0, tx_reg});
        case (state_reg)
            hsamp_pkg::B_R3:
            begin
                mul_a = $signed({h10_reg[31], h10_reg}) - $signed({h00_reg[31], h00_reg});
            end
            hsamp_pkg::B_MB:
            begin
                mul_a = $signed({h11_reg[31], h11_reg}) - $signed({h01_reg[31], h01_reg});
            end
            hsamp_pkg::B_MZ:
            begin
                mul_a = $signed({bot_reg[31], bot_reg}) - $signed({top_reg[31], top_reg});
                mul_b = $signed({1'b0, tz_reg});
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // shared blend adder, floor of the weighted difference
    assign prod_shr = prod_reg >>> FW;

    always_comb
    begin
        case (state_reg)
            hsamp_pkg::B_TOP: blend_base = h00_reg;
            hsamp_pkg::B_BOT: blend_base = h01_reg;
            default:          blend_base = top_reg;
        endcase
    end

    assign blend_sum = {blend_base[31], blend_base} + prod_shr[32:0];

    // sequencer and memory port
    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = grid_addr(head_col, head_row);
        ram_wdata  = head_data;
        out_load   = 1'b0;
        case (state_reg)
            hsamp_pkg::B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    if (head_query)
                    begin
                        state_next = hsamp_pkg::B_R0;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                    end
                end
            end
            hsamp_pkg::B_R0:
            begin
                ram_addr   = grid_addr(ix_reg, iz_reg);
                state_next = hsamp_pkg::B_R1;
            end
            hsamp_pkg::B_R1:
            begin
                ram_addr   = grid_addr(ix1, iz_reg);
                state_next = hsamp_pkg::B_R2;
            end
            hsamp_pkg::B_R2:
            begin
                ram_addr   = grid_addr(ix_reg, iz1);
                state_next = hsamp_pkg::B_R3;
            end
            hsamp_pkg::B_R3:
            begin
                ram_addr   = grid_addr(ix1, iz1);
                state_next = hsamp_pkg::B_TOP;
            end
            hsamp_pkg::B_TOP:
            begin
                state_next = hsamp_pkg::B_MB;
            end
            hsamp_pkg::B_MB:
            begin
                state_next = hsamp_pkg::B_BOT;
            end
            hsamp_pkg::B_BOT:
            begin
                state_next = hsamp_pkg::B_MZ;
            end
            hsamp_pkg::B_MZ:
            begin
                state_next = hsamp_pkg::B_OUT;
            end
            hsamp_pkg::B_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_load   = 1'b1;
                    state_next = hsamp_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = hsamp_pkg::B_IDLE;
            end
        endcase
    end

    // result buffer occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hsamp_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            ix_reg <= head_col;
            iz_reg <= head_row;
            tx_reg <= head_tx;
            tz_reg <= head_tz;
        end
        case (state_reg)
            hsamp_pkg::B_R1:  h00_reg <= ram_rdata;
            hsamp_pkg::B_R2:  h10_reg <= ram_rdata;
            hsamp_pkg::B_R3:  h01_reg <= ram_rdata;
            hsamp_pkg::B_TOP:
            begin
                h11_reg <= ram_rdata;
                top_reg <= blend_sum[31:0];
            end
            hsamp_pkg::B_BOT: bot_reg <= blend_sum[31:0];
            default:
            begin
            end
        endcase
        if ((state_reg == hsamp_pkg::B_R3) || (state_reg == hsamp_pkg::B_MB) ||
            (state_reg == hsamp_pkg::B_MZ))
        begin
            prod_reg <= prod_next;
        end
        if (out_load)
        begin
            out_data_reg <= blend_sum[31:0];
        end
    end

    assign empty          = !out_valid_reg;
    assign sampled_height = out_data_reg;

endmodule

@@ sv/heightgrid_bilinear_sampler_core.sv @@
// height grid bilinear sampler
// input side takes a new item only once the last kept one is in the command queue
// a query holds the back end for four reads through the one grid memory port and
// three passes through the shared blend multiplier; a write is one memory write there
// reset clears control state and sets the configuration registers to their reset values;
// the grid memory is not cleared and an entry holds nothing defined until written
module heightgrid_bilinear_sampler_core #(
    parameter int MAX_GRID_SIZE = hsamp_pkg::MAX_GRID_SIZE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           kind,
    input  logic [7:0]                     column,
    input  logic [7:0]                     row,
    input  logic [31:0]                    height_value,
    input  logic [31:0]                    query_x,
    input  logic [31:0]                    query_z,
    output logic                           empty,
    input  logic                           pop,
    output logic [31:0]                    sampled_height,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hsamp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    localparam int IDX_W  = $clog2(MAX_GRID_SIZE);
    localparam int CMD_W  = 1 + 2 * IDX_W + 2 * hsamp_pkg::FRAC_W + 32;
    localparam int DEPTH  = MAX_GRID_SIZE * MAX_GRID_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [8:0]        grid_size_reg;
    logic [31:0]       origin_x_reg;
    logic [31:0]       origin_z_reg;
    logic [31:0]       inv_spacing_reg;
    logic [IDX_W-1:0]  n_m1;

    logic              cmd_push;
    logic              cmd_full;
    logic [CMD_W-1:0]  cmd_wr_data;
    logic              cmd_pop;
    logic              cmd_empty;
    logic [CMD_W-1:0]  cmd_rd_data;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [31:0]       ram_wdata;
    logic [31:0]       ram_rdata;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg   <= hsamp_pkg::GRID_SIZE_RST;
            origin_x_reg    <= hsamp_pkg::ORIGIN_RST;
            origin_z_reg    <= hsamp_pkg::ORIGIN_RST;
            inv_spacing_reg <= hsamp_pkg::INV_SPACING_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hsamp_pkg::CFG_GRID_SIZE:   grid_size_reg   <= cfg_data[8:0];
                hsamp_pkg::CFG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                hsamp_pkg::CFG_ORIGIN_Z:    origin_z_reg    <= cfg_data;
                hsamp_pkg::CFG_INV_SPACING: inv_spacing_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // last index of the grid size in use, clamped to the supported range
    always_comb
    begin
        if (grid_size_reg < 9'd2)
        begin
            n_m1 = IDX_W'(1);
        end
        else if (int'(grid_size_reg) > MAX_GRID_SIZE)
        begin
            n_m1 = IDX_W'(MAX_GRID_SIZE - 1);
        end
        else
        begin
            n_m1 = IDX_W'(grid_size_reg - 9'd1);
        end
    end

    hsamp_front #(
        .MAX_GRID_SIZE (MAX_GRID_SIZE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .column       (column),
        .row          (row),
        .height_value (height_value),
        .query_x      (query_x),
        .query_z      (query_z),
        .origin_x     (origin_x_reg),
        .origin_z     (origin_z_reg),
        .inv_spacing  (inv_spacing_reg),
        .n_m1         (n_m1),
        .cmd_push     (cmd_push),
        .cmd_full     (cmd_full),
        .cmd_data     (cmd_wr_data)
    );

    hsamp_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_wr_data),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_rd_data),
        .empty   (cmd_empty)
    );

    hsamp_back #(
        .MAX_GRID_SIZE (MAX_GRID_SIZE)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .n_m1           (n_m1),
        .cmd_data       (cmd_rd_data),
        .cmd_empty      (cmd_empty),
        .cmd_pop        (cmd_pop),
        .ram_we         (ram_we),
        .ram_addr       (ram_addr),
        .ram_wdata      (ram_wdata),
        .ram_rdata      (ram_rdata),
        .empty          (empty),
        .pop            (pop),
        .sampled_height (sampled_height)
    );

    hsamp_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // front end never pushes into a full command queue
    assert property (@(posedge clk) disable iff (!rst_n) !(cmd_push && cmd_full))
        else $error("command pushed into full queue");

    // back end never takes a command that is not there
    assert property (@(posedge clk) disable iff (!rst_n) !(cmd_pop && cmd_empty))
        else $error("command popped from empty queue");

    // grid writes stay inside the grid memory
    assert property (@(posedge clk) disable iff (!rst_n) ram_we |-> (int'(ram_addr) < DEPTH))
        else $error("grid write address out of range");

endmodule
